### rtl/lpsf_pkg.sv
// ----------------------------------------------------------------------------
// lpsf_pkg
// Shared types and codes of the primary-station link state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsf_pkg;

	// Low bits of payload_tag kept for a held data frame
	localparam int TAG_BITS = 8;
	localparam int TagW     = (TAG_BITS < 8) ? TAG_BITS : 8;

	// Event opcodes
	localparam logic [2:0] OP_SEND_CONF   = 3'd0;
	localparam logic [2:0] OP_SEND_UNCONF = 3'd1;
	localparam logic [2:0] OP_ACK         = 3'd2;
	localparam logic [2:0] OP_NACK        = 3'd3;
	localparam logic [2:0] OP_LINK_STATUS = 3'd4;
	localparam logic [2:0] OP_NOT_SUPP    = 3'd5;
	localparam logic [2:0] OP_TIMEOUT     = 3'd6;
	localparam logic [2:0] OP_FAILURE     = 3'd7;

	// Link states
	localparam logic [1:0] ST_NOT_RESET  = 2'd0;
	localparam logic [1:0] ST_RESET      = 2'd1;
	localparam logic [1:0] ST_RESET_WAIT = 2'd2;
	localparam logic [1:0] ST_DATA_WAIT  = 2'd3;

	// Frame kinds
	localparam logic [1:0] KIND_NONE        = 2'd0;
	localparam logic [1:0] KIND_UNCONF_DATA = 2'd1;
	localparam logic [1:0] KIND_RESET_LINKS = 2'd2;
	localparam logic [1:0] KIND_CONF_DATA   = 2'd3;

	// Timer commands
	localparam logic [1:0] TMR_NONE         = 2'd0;
	localparam logic [1:0] TMR_START        = 2'd1;
	localparam logic [1:0] TMR_CANCEL       = 2'd2;
	localparam logic [1:0] TMR_CANCEL_START = 2'd3;

	// Reports
	localparam logic [1:0] RPT_NONE    = 2'd0;
	localparam logic [1:0] RPT_SUCCESS = 2'd1;
	localparam logic [1:0] RPT_FAILURE = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE          = 3'd0;
	localparam logic [2:0] ERR_UNEXPECTED    = 3'd1;
	localparam logic [2:0] ERR_INVALID_STATE = 3'd2;
	localparam logic [2:0] ERR_RETRY_TIMEOUT = 3'd3;
	localparam logic [2:0] ERR_FINAL_TIMEOUT = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_IS_MASTER   = 2'd0;
	localparam logic [1:0] REG_REMOTE_ADDR = 2'd1;
	localparam logic [1:0] REG_LOCAL_ADDR  = 2'd2;
	localparam logic [1:0] REG_MAX_RETRIES = 2'd3;

	typedef struct packed {
		logic        is_master;
		logic [15:0] remote_addr;
		logic [15:0] local_addr;
		logic [7:0]  max_retries;
	} cfg_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] payload_tag;
		logic [7:0] payload_length;
	} event_t;

	typedef struct packed {
		logic [1:0]  send_kind;
		logic        frame_count_bit;
		logic [1:0]  timer_cmd;
		logic [1:0]  report;
		logic [2:0]  error_code;
		logic [7:0]  frame_tag;
		logic [7:0]  frame_length;
		logic        dir_bit;
		logic [15:0] dest_addr;
		logic [15:0] src_addr;
		logic [1:0]  link_state_out;
		logic [7:0]  retries_out;
	} action_t;

endpackage

`default_nettype wire

### rtl/lpsf_in_if.sv
// ----------------------------------------------------------------------------
// lpsf_in_if
// Event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpsf_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] payload_tag;
	logic [7:0] payload_length;

	modport source (output valid, output opcode, output payload_tag,
		output payload_length, input ready);
	modport sink (input valid, input opcode, input payload_tag,
		input payload_length, output ready);
endinterface

`default_nettype wire

### rtl/lpsf_out_if.sv
// ----------------------------------------------------------------------------
// lpsf_out_if
// Action channel: valid/ready handshake with the action word fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpsf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  send_kind;
	logic        frame_count_bit;
	logic [1:0]  timer_cmd;
	logic [1:0]  report;
	logic [2:0]  error_code;
	logic [7:0]  frame_tag;
	logic [7:0]  frame_length;
	logic        dir_bit;
	logic [15:0] dest_addr;
	logic [15:0] src_addr;
	logic [1:0]  link_state_out;
	logic [7:0]  retries_out;

	modport source (output valid, output send_kind, output frame_count_bit,
		output timer_cmd, output report, output error_code, output frame_tag,
		output frame_length, output dir_bit, output dest_addr, output src_addr,
		output link_state_out, output retries_out, input ready);
	modport sink (input valid, input send_kind, input frame_count_bit,
		input timer_cmd, input report, input error_code, input frame_tag,
		input frame_length, input dir_bit, input dest_addr, input src_addr,
		input link_state_out, input retries_out, output ready);
endinterface

`default_nettype wire

### rtl/link_primary_station_fsm_unit.sv
// ----------------------------------------------------------------------------
// link_primary_station_fsm_unit
// Primary-station link-layer state machine: one action word per event.
// ----------------------------------------------------------------------------
// Path: an event transfer loads the input register; the action register then
//   takes the action word once it is empty or being drained.
// Throughput: one event per cycle unless out_ch stalls; the state update is
//   a single pass of shallow logic between the input and action registers.
// Reset: arst_n clears both stage valids, sets link not reset, frame count
//   bit 1, retries 0, and loads the configuration reset values.
`default_nettype none

module link_primary_station_fsm_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	lpsf_in_if.sink          in_ch,
	lpsf_out_if.source       out_ch
);
	import lpsf_pkg::*;

	cfg_t    cfg;
	event_t  evt_s1;
	logic    valid_s1;
	action_t act;
	action_t act_s2;
	logic    valid_s2;
	logic    adv_s2;
	logic    adv_s1;

	lpsf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage 2 takes a new word when empty or being drained
	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_ch.valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) begin
			evt_s1.opcode         <= in_ch.opcode;
			evt_s1.payload_tag    <= in_ch.payload_tag;
			evt_s1.payload_length <= in_ch.payload_length;
		end
		if (adv_s2 && valid_s1)
			act_s2 <= act;
	end

	lpsf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_fire (valid_s1 && adv_s2),
		.evt      (evt_s1),
		.cfg      (cfg),
		.act      (act)
	);

	assign out_ch.valid           = valid_s2;
	assign out_ch.send_kind       = act_s2.send_kind;
	assign out_ch.frame_count_bit = act_s2.frame_count_bit;
	assign out_ch.timer_cmd       = act_s2.timer_cmd;
	assign out_ch.report          = act_s2.report;
	assign out_ch.error_code      = act_s2.error_code;
	assign out_ch.frame_tag       = act_s2.frame_tag;
	assign out_ch.frame_length    = act_s2.frame_length;
	assign out_ch.dir_bit         = act_s2.dir_bit;
	assign out_ch.dest_addr       = act_s2.dest_addr;
	assign out_ch.src_addr        = act_s2.src_addr;
	assign out_ch.link_state_out  = act_s2.link_state_out;
	assign out_ch.retries_out     = act_s2.retries_out;

endmodule

`default_nettype wire

### rtl/lpsf_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpsf_cfg_regs
// Configuration registers: header fields and retry limit.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsf_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_wdata,
	output lpsf_pkg::cfg_t     cfg
);
	import lpsf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.is_master   <= 1'b1;
			cfg_q.remote_addr <= 16'd1;
			cfg_q.local_addr  <= 16'd1;
			cfg_q.max_retries <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IS_MASTER:   cfg_q.is_master   <= cfg_wdata[0];
				REG_REMOTE_ADDR: cfg_q.remote_addr <= cfg_wdata;
				REG_LOCAL_ADDR:  cfg_q.local_addr  <= cfg_wdata;
				REG_MAX_RETRIES: cfg_q.max_retries <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/lpsf_core.sv
// ----------------------------------------------------------------------------
// lpsf_core
// Link state registers and the per-event next-state and action logic.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsf_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              evt_fire,
	input  wire lpsf_pkg::event_t  evt,
	input  wire lpsf_pkg::cfg_t    cfg,
	output lpsf_pkg::action_t      act
);
	import lpsf_pkg::*;

	logic [1:0]      state_q;
	logic            fcb_q;
	logic [7:0]      retries_q;
	logic [TagW-1:0] held_tag_q;
	logic [7:0]      held_len_q;

	logic [1:0] state_d;
	logic       fcb_d;
	logic [7:0] retries_d;
	logic       hold_we;
	logic       hdr_en;
	logic       idle;
	logic [TagW-1:0] evt_tag;

	always_comb begin
		evt_tag   = TagW'(evt.payload_tag);
		idle      = state_q inside {ST_NOT_RESET, ST_RESET};
		state_d   = state_q;
		fcb_d     = fcb_q;
		retries_d = retries_q;
		hold_we   = 1'b0;
		hdr_en    = 1'b0;
		act       = '0;

		case (evt.opcode)
			OP_SEND_CONF: begin
				if (!idle) begin
					act.error_code = ERR_INVALID_STATE;
				end else begin
					retries_d     = cfg.max_retries;
					hold_we       = 1'b1;
					act.timer_cmd = TMR_START;
					hdr_en        = 1'b1;
					if (state_q == ST_NOT_RESET) begin
						state_d       = ST_RESET_WAIT;
						act.send_kind = KIND_RESET_LINKS;
					end else begin
						state_d             = ST_DATA_WAIT;
						act.send_kind       = KIND_CONF_DATA;
						act.frame_count_bit = fcb_q;
						act.frame_tag       = 8'(evt_tag);
						act.frame_length    = evt.payload_length;
					end
				end
			end
			OP_SEND_UNCONF: begin
				if (!idle) begin
					act.error_code = ERR_INVALID_STATE;
				end else begin
					hdr_en           = 1'b1;
					act.send_kind    = KIND_UNCONF_DATA;
					act.frame_tag    = 8'(evt_tag);
					act.frame_length = evt.payload_length;
				end
			end
			OP_ACK: begin
				if (state_q == ST_RESET_WAIT) begin
					fcb_d               = 1'b1;
					state_d             = ST_DATA_WAIT;
					act.timer_cmd       = TMR_CANCEL_START;
					hdr_en              = 1'b1;
					act.send_kind       = KIND_CONF_DATA;
					act.frame_count_bit = 1'b1;
					act.frame_tag       = 8'(held_tag_q);
					act.frame_length    = held_len_q;
				end else if (state_q == ST_DATA_WAIT) begin
					fcb_d         = ~fcb_q;
					state_d       = ST_RESET;
					act.timer_cmd = TMR_CANCEL;
					act.report    = RPT_SUCCESS;
				end else begin
					act.error_code = ERR_UNEXPECTED;
				end
			end
			OP_TIMEOUT: begin
				if (idle) begin
					act.error_code = ERR_INVALID_STATE;
				end else if (retries_q != 8'd0) begin
					retries_d      = retries_q - 8'd1;
					act.error_code = ERR_RETRY_TIMEOUT;
					act.timer_cmd  = TMR_START;
					hdr_en         = 1'b1;
					if (state_q == ST_RESET_WAIT) begin
						act.send_kind = KIND_RESET_LINKS;
					end else begin
						act.send_kind       = KIND_CONF_DATA;
						act.frame_count_bit = fcb_q;
						act.frame_tag       = 8'(held_tag_q);
						act.frame_length    = held_len_q;
					end
				end else begin
					// timer already expired: no timer command
					act.error_code = ERR_FINAL_TIMEOUT;
					state_d        = ST_NOT_RESET;
					act.report     = RPT_FAILURE;
				end
			end
			OP_FAILURE: begin
				if (idle) begin
					act.error_code = ERR_INVALID_STATE;
				end else begin
					act.timer_cmd = TMR_CANCEL;
					state_d       = ST_NOT_RESET;
					act.report    = RPT_FAILURE;
				end
			end
			default: begin
				act.error_code = ERR_UNEXPECTED;
			end
		endcase

		if (hdr_en) begin
			act.dir_bit   = cfg.is_master;
			act.dest_addr = cfg.remote_addr;
			act.src_addr  = cfg.local_addr;
		end
		act.link_state_out = state_d;
		act.retries_out    = retries_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_NOT_RESET;
			fcb_q     <= 1'b1;
			retries_q <= 8'd0;
		end else if (evt_fire) begin
			state_q   <= state_d;
			fcb_q     <= fcb_d;
			retries_q <= retries_d;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_fire && hold_we) begin
			held_tag_q <= evt_tag;
			held_len_q <= evt.payload_length;
		end
	end

endmodule

`default_nettype wire

### tb/link_primary_station_fsm_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_primary_station_fsm_unit_test
// Self-checking bench for the primary-station link state machine. Events are
// sent in random bursts. Each accepted event is run through a local copy of
// the link state machine, and the action word it should cause is queued. Each
// action that comes out is compared field by field with the oldest queued one.
// The bench covers several address and retry settings, including the extremes.
// ----------------------------------------------------------------------------

module link_primary_station_fsm_unit_test;
	import lpsf_pkg::*;

	localparam logic [7:0] TagMask = 8'((1 << TagW) - 1);
	localparam int HoldAt = 300;
	localparam int HoldCycles = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_wdata;

	lpsf_in_if event_ch ();
	lpsf_out_if action_ch ();

	link_primary_station_fsm_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (event_ch),
		.out_ch    (action_ch)
	);

	// Local copy of the link state and its configuration
	cfg_t shadow_cfg = '{is_master: 1'b1, remote_addr: 16'd1, local_addr: 16'd1,
		max_retries: 8'd0};
	logic [1:0] lk_state = ST_NOT_RESET;
	logic lk_fcb = 1'b1;
	logic [7:0] lk_retries = 8'd0;
	logic [7:0] lk_tag = 8'd0;
	logic [7:0] lk_len = 8'd0;

	event_t event_backlog[$];
	action_t awaited_actions[$];
	int events_queued = 0;
	int events_taken = 0;
	int actions_taken = 0;
	int fail_count = 0;

	event_t on_wire;
	int burst_left = 8;
	int gap_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	logic [15:0] stall_pat = '1;
	int pat_age = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void stamp_header(inout action_t a);
		a.dir_bit = shadow_cfg.is_master;
		a.dest_addr = shadow_cfg.remote_addr;
		a.src_addr = shadow_cfg.local_addr;
	endfunction

	function automatic void stamp_frame(inout action_t a, input logic [1:0] kind,
		input logic fcb, input logic [7:0] tag, input logic [7:0] len);
		a.send_kind = kind;
		a.frame_count_bit = fcb;
		a.frame_tag = tag;
		a.frame_length = len;
		stamp_header(a);
	endfunction

	// Advance the local link state by one event and return its action word
	function automatic void link_step(input event_t ev, output action_t act);
		logic [7:0] tag;
		logic idle;
		tag = ev.payload_tag & TagMask;
		idle = (lk_state == ST_NOT_RESET) || (lk_state == ST_RESET);
		act = '0;
		case (ev.opcode)
			OP_SEND_CONF: begin
				if (!idle) begin
					act.error_code = ERR_INVALID_STATE;
				end else begin
					lk_retries = shadow_cfg.max_retries;
					lk_tag = tag;
					lk_len = ev.payload_length;
					act.timer_cmd = TMR_START;
					if (lk_state == ST_NOT_RESET) begin
						lk_state = ST_RESET_WAIT;
						act.send_kind = KIND_RESET_LINKS;
						stamp_header(act);
					end else begin
						lk_state = ST_DATA_WAIT;
						stamp_frame(act, KIND_CONF_DATA, lk_fcb, lk_tag, lk_len);
					end
				end
			end
			OP_SEND_UNCONF: begin
				if (!idle)
					act.error_code = ERR_INVALID_STATE;
				else
					stamp_frame(act, KIND_UNCONF_DATA, 1'b0, tag, ev.payload_length);
			end
			OP_ACK: begin
				if (lk_state == ST_RESET_WAIT) begin
					lk_fcb = 1'b1;
					act.timer_cmd = TMR_CANCEL_START;
					lk_state = ST_DATA_WAIT;
					stamp_frame(act, KIND_CONF_DATA, lk_fcb, lk_tag, lk_len);
				end else if (lk_state == ST_DATA_WAIT) begin
					lk_fcb = ~lk_fcb;
					act.timer_cmd = TMR_CANCEL;
					lk_state = ST_RESET;
					act.report = RPT_SUCCESS;
				end else begin
					act.error_code = ERR_UNEXPECTED;
				end
			end
			OP_TIMEOUT: begin
				if (idle) begin
					act.error_code = ERR_INVALID_STATE;
				end else if (lk_retries != 8'd0) begin
					lk_retries = lk_retries - 8'd1;
					act.error_code = ERR_RETRY_TIMEOUT;
					act.timer_cmd = TMR_START;
					if (lk_state == ST_RESET_WAIT) begin
						act.send_kind = KIND_RESET_LINKS;
						stamp_header(act);
					end else begin
						stamp_frame(act, KIND_CONF_DATA, lk_fcb, lk_tag, lk_len);
					end
				end else begin
					// timer already expired: no timer command
					act.error_code = ERR_FINAL_TIMEOUT;
					lk_state = ST_NOT_RESET;
					act.report = RPT_FAILURE;
				end
			end
			OP_FAILURE: begin
				if (idle) begin
					act.error_code = ERR_INVALID_STATE;
				end else begin
					act.timer_cmd = TMR_CANCEL;
					lk_state = ST_NOT_RESET;
					act.report = RPT_FAILURE;
				end
			end
			default: begin
				act.error_code = ERR_UNEXPECTED;
			end
		endcase
		act.link_state_out = lk_state;
		act.retries_out = lk_retries;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Event driver: bursts of transfers separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			event_ch.valid <= 1'b0;
		end else begin
			if (event_ch.valid && event_ch.ready) begin
				action_t act;
				link_step(on_wire, act);
				awaited_actions.push_back(act);
				events_taken++;
			end
			if (!event_ch.valid || event_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					event_ch.valid <= 1'b0;
				end else if (event_backlog.size() > 0) begin
					on_wire = event_backlog.pop_front();
					event_ch.opcode <= on_wire.opcode;
					event_ch.payload_tag <= on_wire.payload_tag;
					event_ch.payload_length <= on_wire.payload_length;
					event_ch.valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					event_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Action monitor: checks each transfer and stalls on a rotating pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			action_ch.ready <= 1'b0;
		end else begin
			if (action_ch.valid && action_ch.ready) begin
				action_t want;
				actions_taken++;
				if (awaited_actions.size() == 0) begin
					fail_count++;
					$display("%0t: action with none expected, actual %h", $time,
						action_ch.send_kind);
				end else begin
					want = awaited_actions.pop_front();
					check_field("send_kind", want.send_kind, action_ch.send_kind);
					check_field("frame_count_bit", want.frame_count_bit,
						action_ch.frame_count_bit);
					check_field("timer_cmd", want.timer_cmd, action_ch.timer_cmd);
					check_field("report", want.report, action_ch.report);
					check_field("error_code", want.error_code, action_ch.error_code);
					check_field("frame_tag", want.frame_tag, action_ch.frame_tag);
					check_field("frame_length", want.frame_length, action_ch.frame_length);
					check_field("dir_bit", want.dir_bit, action_ch.dir_bit);
					check_field("dest_addr", want.dest_addr, action_ch.dest_addr);
					check_field("src_addr", want.src_addr, action_ch.src_addr);
					check_field("link_state_out", want.link_state_out,
						action_ch.link_state_out);
					check_field("retries_out", want.retries_out, action_ch.retries_out);
				end
			end
			// hold off once for a long stretch so the event side backs up
			if (hold_left > 0) begin
				hold_left--;
				action_ch.ready <= 1'b0;
			end else if (actions_taken >= HoldAt && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HoldCycles;
				action_ch.ready <= 1'b0;
			end else begin
				if (pat_age == 0) begin
					stall_pat = ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom);
					pat_age = 48;
				end
				pat_age--;
				action_ch.ready <= stall_pat[0];
				stall_pat = {stall_pat[0], stall_pat[15:1]};
			end
		end
	end

	task automatic queue_event(input logic [2:0] op, input logic [7:0] tag,
		input logic [7:0] len);
		event_t ev;
		ev.opcode = op;
		ev.payload_tag = tag;
		ev.payload_length = len;
		event_backlog.push_back(ev);
		events_queued++;
	endtask

	task automatic queue_any(input logic [2:0] op);
		queue_event(op, 8'($urandom), 8'($urandom_range(0, 250)));
	endtask

	// Mostly confirmed exchanges with timeouts, plus noise and plain sends
	task automatic queue_random_traffic(input int count);
		int made;
		made = 0;
		while (made < count) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					queue_any(3'($urandom_range(0, 7)));
					made++;
				end
				2: begin
					queue_any(OP_SEND_UNCONF);
					made++;
				end
				default: begin
					queue_any(OP_SEND_CONF);
					made++;
					repeat (2) begin
						repeat ($urandom_range(0, 3)) begin
							queue_any(OP_TIMEOUT);
							made++;
						end
						queue_any(($urandom_range(0, 7) == 0) ? OP_FAILURE : OP_ACK);
						made++;
					end
				end
			endcase
		end
	endtask

	// Wait until every event has gone through and its action has arrived
	task automatic drain();
		do @(posedge clk);
		while (events_taken != events_queued || awaited_actions.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_IS_MASTER: shadow_cfg.is_master = val[0];
			REG_REMOTE_ADDR: shadow_cfg.remote_addr = val;
			REG_LOCAL_ADDR: shadow_cfg.local_addr = val;
			REG_MAX_RETRIES: shadow_cfg.max_retries = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic dir, input logic [15:0] remote,
		input logic [15:0] local_id, input logic [7:0] retries);
		drain();
		write_reg(REG_IS_MASTER, {15'd0, dir});
		write_reg(REG_REMOTE_ADDR, remote);
		write_reg(REG_LOCAL_ADDR, local_id);
		write_reg(REG_MAX_RETRIES, {8'd0, retries});
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_index = REG_IS_MASTER;
		cfg_wdata = 16'd0;
		event_ch.valid = 1'b0;
		event_ch.opcode = OP_SEND_CONF;
		event_ch.payload_tag = 8'd0;
		event_ch.payload_length = 8'd0;
		action_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: no retries
		queue_event(OP_ACK, 8'h00, 8'd0);
		queue_event(OP_NACK, 8'h00, 8'd0);
		queue_event(OP_LINK_STATUS, 8'h00, 8'd0);
		queue_event(OP_NOT_SUPP, 8'h00, 8'd0);
		queue_event(OP_TIMEOUT, 8'h00, 8'd0);
		queue_event(OP_FAILURE, 8'h00, 8'd0);
		queue_event(OP_SEND_UNCONF, 8'hFF, 8'd250);
		queue_event(OP_SEND_UNCONF, 8'h00, 8'd0);
		queue_event(OP_SEND_CONF, 8'hA5, 8'd250);
		queue_event(OP_SEND_CONF, 8'h00, 8'd0);
		queue_event(OP_SEND_UNCONF, 8'h3C, 8'd7);
		queue_event(OP_ACK, 8'h00, 8'd0);
		queue_event(OP_NACK, 8'h00, 8'd0);
		queue_event(OP_ACK, 8'h00, 8'd0);
		queue_event(OP_ACK, 8'h00, 8'd0);
		queue_event(OP_SEND_CONF, 8'h5A, 8'd1);
		queue_event(OP_TIMEOUT, 8'h00, 8'd0);
		queue_event(OP_SEND_CONF, 8'hFF, 8'd250);
		queue_event(OP_FAILURE, 8'h00, 8'd0);
		queue_event(OP_TIMEOUT, 8'h00, 8'd0);

		// Two retries, then a final timeout from the data wait
		set_config(1'b0, 16'hFFFF, 16'h0000, 8'd2);
		queue_event(OP_SEND_CONF, 8'h0F, 8'd15);
		queue_event(OP_TIMEOUT, 8'h00, 8'd0);
		queue_event(OP_ACK, 8'h00, 8'd0);
		queue_event(OP_TIMEOUT, 8'h00, 8'd0);
		queue_event(OP_TIMEOUT, 8'h00, 8'd0);
		queue_random_traffic(200);

		set_config(1'b1, 16'h0000, 16'hFFFF, 8'd255);
		queue_random_traffic(200);

		set_config(1'($urandom), 16'($urandom), 16'($urandom), 8'd1);
		queue_random_traffic(200);

		set_config(1'($urandom), 16'($urandom), 16'($urandom), 8'd0);
		queue_random_traffic(200);

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("link_primary_station_fsm_unit test passed");
		else
			$display("link_primary_station_fsm_unit test failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("%0t: timeout", $time);
		$display("link_primary_station_fsm_unit test failed");
		$finish;
	end

endmodule
